// ----- hw/rtl/rrpq_pkg.sv -----
// Shared types, operation codes and rank compare for the ranked record priority queue.
`default_nettype none
package rrpq_pkg;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_PEEK = 2'd1;
  localparam logic [1:0] OP_POP  = 2'd2;
  localparam logic [1:0] OP_RSVD = 2'd3;

  typedef struct packed {
    logic [15:0] tag;
    logic [15:0] roll;
    logic [15:0] marks;
  } rec_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] name_tag;
    logic [15:0] roll;
    logic [15:0] marks;
  } in_word_t;

  typedef struct packed {
    logic [15:0] top_name_tag;
    logic [15:0] top_roll;
    logic [15:0] top_marks;
    logic        is_empty;
    logic        overflow;
  } out_word_t;

  // higher marks first, lower roll on a tie
  function automatic logic ranks_above(rec_t a, rec_t b);
    logic res;
    if (a.marks != b.marks) begin
      res = (a.marks > b.marks);
    end else begin
      res = (a.roll < b.roll);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/rrpq_heap_mem.sv -----
// Heap record store: one write port, two registered read ports.
`default_nettype none
module rrpq_heap_mem
  import rrpq_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire rec_t                     wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output rec_t                          rd_data_a,
  output rec_t                          rd_data_b
);

  rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/ranked_record_priority_queue.sv -----
// Top level: bounded max heap of ranked records with push, peek and pop.
//
//  channel | ports                    | handshake
//  --------+--------------------------+-----------------------------------
//  input   | start, busy, in_word     | taken when start & !busy
//  result  | out_valid, out_word      | one-cycle strobe, cannot be held
//
// Peek, overflowing push, pop of an empty queue: result in the cycle after accept.
// Push climbs from the new leaf toward the root; pop moves the last record to the root
// and sifts it down toward a leaf; each level takes one read and one compare/write.
// Synchronous reset empties the queue at once; the store is not cleared.
// busy stays high until the result strobe; no result is ever stalled.
`default_nettype none
module ranked_record_priority_queue
  import rrpq_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_word_t in_word,
  output logic          out_valid,
  output out_word_t     out_word
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_ISSUE,
    S_UP_CMP,
    S_LAST,
    S_DN_ISSUE,
    S_DN_CMP
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  rec_t            cur_r, cur_nxt;
  rec_t            top_r, top_nxt;
  logic            out_valid_r;
  out_word_t       out_word_r, out_word_nxt;

  logic            fin;
  logic            ovf;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  rec_t            wr_data;
  logic [AW-1:0]   rd_addr_a;
  logic [AW-1:0]   rd_addr_b;
  rec_t            rd_data_a;
  rec_t            rd_data_b;

  logic [AW+1:0]   left_w;
  logic [AW+1:0]   right_w;
  logic [AW+1:0]   count_w;
  logic [AW-1:0]   parent;
  logic            right_ok;
  logic            pick_right;
  rec_t            child;
  rec_t            in_rec;

  rrpq_heap_mem #(
    .DEPTH(CAPACITY)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  assign left_w     = {1'b0, idx_r, 1'b1};
  assign right_w    = left_w + (AW+2)'(1);
  assign count_w    = (AW+2)'(count_r);
  assign parent     = (idx_r - AW'(1)) >> 1;
  assign right_ok   = (right_w < count_w);
  assign pick_right = right_ok && ranks_above(rd_data_b, rd_data_a);
  assign child      = pick_right ? rd_data_b : rd_data_a;
  assign in_rec     = '{tag: in_word.name_tag, roll: in_word.roll, marks: in_word.marks};

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    cur_nxt   = cur_r;
    fin       = 1'b0;
    ovf       = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    wr_data   = cur_r;
    rd_addr_a = left_w[AW-1:0];
    rd_addr_b = right_w[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        rd_addr_a = AW'(count_r - CW'(1));
        if (start) begin
          case (in_word.operation)
            OP_PUSH: begin
              if (count_r == CW'(CAPACITY)) begin
                fin = 1'b1;
                ovf = 1'b1;
              end else begin
                count_nxt = count_r + CW'(1);
                idx_nxt   = count_r[AW-1:0];
                cur_nxt   = in_rec;
                state_nxt = S_UP_ISSUE;
              end
            end
            OP_POP: begin
              if (count_r == '0) begin
                fin = 1'b1;
              end else begin
                count_nxt = count_r - CW'(1);
                state_nxt = S_LAST;
              end
            end
            default: fin = 1'b1;
          endcase
        end
      end
      S_UP_ISSUE: begin
        rd_addr_a = parent;
        if (idx_r == '0) begin
          wr_en     = 1'b1;
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        wr_en = 1'b1;
        if (ranks_above(cur_r, rd_data_a)) begin
          wr_data   = rd_data_a;
          idx_nxt   = parent;
          state_nxt = S_UP_ISSUE;
        end else begin
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_LAST: begin
        cur_nxt = rd_data_a;
        idx_nxt = '0;
        if (count_r == '0) begin
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_DN_ISSUE;
        end
      end
      S_DN_ISSUE: begin
        if (left_w >= count_w) begin
          wr_en     = 1'b1;
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        wr_en = 1'b1;
        if (ranks_above(child, cur_r)) begin
          wr_data   = child;
          idx_nxt   = pick_right ? right_w[AW-1:0] : left_w[AW-1:0];
          state_nxt = S_DN_ISSUE;
        end else begin
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    top_nxt = top_r;
    if (wr_en && (wr_addr == '0)) begin
      top_nxt = wr_data;
    end
    out_word_nxt.overflow = ovf;
    if (count_nxt == '0) begin
      out_word_nxt.top_name_tag = '0;
      out_word_nxt.top_roll     = '0;
      out_word_nxt.top_marks    = '0;
      out_word_nxt.is_empty     = 1'b1;
    end else begin
      out_word_nxt.top_name_tag = top_nxt.tag;
      out_word_nxt.top_roll     = top_nxt.roll;
      out_word_nxt.top_marks    = top_nxt.marks;
      out_word_nxt.is_empty     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= fin;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    cur_r <= cur_nxt;
    top_r <= top_nxt;
    if (fin) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
`default_nettype wire

// ----- hw/rtl/rrpq_checker.sv -----
// Port-level checks for the ranked record priority queue, bound to the top level.
`default_nettype none
module rrpq_checker
  import rrpq_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire in_word_t  in_word,
  input wire logic      out_valid,
  input wire out_word_t out_word
);

  // a full queue is never empty
  a_ovf_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_word.is_empty && out_word.overflow))
    else $error("overflow reported on empty queue");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.is_empty) |->
      (out_word.top_name_tag == '0 && out_word.top_roll == '0 &&
       out_word.top_marks == '0))
    else $error("empty result carries a record");

  a_peek_next: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_word.operation == OP_PEEK || in_word.operation == OP_RSVD))
      |=> (out_valid && !out_word.overflow))
    else $error("peek result missing");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

endmodule

bind ranked_record_priority_queue rrpq_checker u_rrpq_checker (.*);
`default_nettype wire
